[design/id3fw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_pkg
// Shared types, codes and constants of the ID3v2 frame walker.
// ----------------------------------------------------------------------------
package id3fw_pkg;

    // walk phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR,
        PH_EXTLEN,
        PH_EXTSKIP,
        PH_FRHDR,
        PH_BODY
    } phase_t;

    // result event codes
    typedef enum logic [1:0] {
        EV_FOUND = 2'd0,
        EV_BYTE  = 2'd1,
        EV_DONE  = 2'd2,
        EV_ERROR = 2'd3
    } event_t;

    // frame kind codes
    localparam logic [2:0] KIND_TLEN  = 3'd0;
    localparam logic [2:0] KIND_OTHER = 3'd6;
    localparam int         NUM_WANTED = 6;

    // wanted frame ids, in kind order: TLEN TPE1 TIT2 TALB TRCK TYER
    localparam logic [31:0] WANTED_IDS [NUM_WANTED] = '{
        32'h544C_454E, 32'h5450_4531, 32'h5449_5432,
        32'h5441_4C42, 32'h5452_434B, 32'h5459_4552
    };

    // header and flag constants
    localparam logic [7:0]  EXT_FLAG_MASK = 8'h40;
    localparam logic [7:0]  ENC_MASK      = 8'h06;
    localparam logic [7:0]  COMP_MASK     = 8'h08;
    localparam logic [27:0] PAD_BYTES     = 28'd10;
    localparam logic [27:0] FRAME_HDR_LEN = 28'd10;
    localparam logic [31:0] EXT_MIN_LEN   = 32'd4;

    // byte positions within the headers
    localparam logic [3:0] IDX_EXT_FLAG  = 4'd5;
    localparam logic [3:0] IDX_SIZE_0    = 4'd6;
    localparam logic [3:0] IDX_HDR_LAST  = 4'd9;
    localparam logic [3:0] IDX_EXT_LAST  = 4'd3;
    localparam logic [3:0] IDX_ID_END    = 4'd4;
    localparam logic [3:0] IDX_LEN_END   = 4'd8;
    localparam logic [3:0] IDX_FRH_LAST  = 4'd9;

    // result queue depth, as a power of two (at least 2)
    localparam int RES_FIFO_LOG2 = 2;

    // one result item
    typedef struct packed {
        event_t      event_res;
        logic [2:0]  frame_kind;
        logic [31:0] frame_length;
        logic        is_compressed;
        logic        is_encrypted;
        logic [7:0]  payload;
        logic        frame_end;
        logic        last;
    } res_t;

    // up to two results written into the queue in one cycle
    typedef struct packed {
        logic v0;
        logic v1;
        res_t r0;
        res_t r1;
    } res_push_t;

    // frame id to kind code
    function automatic logic [2:0] frame_kind_of(input logic [31:0] id);
        logic [2:0] k;
        k = KIND_OTHER;
        for (int i = NUM_WANTED - 1; i >= 0; i--) begin
            if (id == WANTED_IDS[i]) begin
                k = KIND_TLEN + 3'(i);
            end
        end
        return k;
    endfunction

endpackage

[design/id3fw_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_walk
// Per-byte tag walker: header, extended header, frame headers and bodies.
// Updates the walk state and produces up to two results for each byte.
// ----------------------------------------------------------------------------
module id3fw_walk (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_fire,
    input  logic                  start_req,
    input  logic [7:0]            data_byte,
    output id3fw_pkg::res_push_t  push
);
    import id3fw_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic        ext_flag_reg, ext_flag_next;
    logic [27:0] rem_reg, rem_next;
    logic [31:0] id_reg, id_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] body_reg, body_next;
    logic [2:0]  kind_reg, kind_next;
    logic        pass_reg, pass_next;

    // state as seen by this byte: a start clears it first
    phase_t      ph_eff;
    logic [3:0]  idx_eff;
    logic        ext_eff;
    logic [27:0] rem_eff;
    logic [31:0] id_eff, len_eff, body_eff;
    logic [2:0]  kind_eff;
    logic        pass_eff;

    logic [31:0] len_shift, ext_len, body_dec;
    logic [27:0] rem_hdr, rem_ext, rem_less10, rem_after, chk_rem;
    logic        ext_short, frame_ovr, chk_done, comp, enc;
    logic [2:0]  kind_new;

    res_t        res_a, res_d;
    logic        a_v, d_v;

    // effective state and shared datapath terms
    always_comb begin
        ph_eff   = start_req ? PH_HDR : phase_reg;
        idx_eff  = start_req ? '0 : byte_index_reg;
        ext_eff  = start_req ? 1'b0 : ext_flag_reg;
        rem_eff  = start_req ? '0 : rem_reg;
        id_eff   = start_req ? '0 : id_reg;
        len_eff  = start_req ? '0 : len_reg;
        body_eff = start_req ? '0 : body_reg;
        kind_eff = start_req ? KIND_OTHER : kind_reg;
        pass_eff = start_req ? 1'b0 : pass_reg;

        len_shift  = {len_eff[23:0], data_byte};
        ext_len    = (len_shift < EXT_MIN_LEN) ? EXT_MIN_LEN : len_shift;
        ext_short  = {4'd0, rem_eff} < ext_len;
        rem_ext    = rem_eff - ext_len[27:0];
        rem_hdr    = {rem_eff[20:0], data_byte[6:0]};
        rem_less10 = rem_eff - FRAME_HDR_LEN;
        frame_ovr  = {4'd0, rem_less10} < len_eff;
        rem_after  = rem_less10 - len_eff[27:0];
        body_dec   = body_eff - {31'd0, (body_eff != '0)};
        kind_new   = frame_kind_of(id_eff);
        comp       = (data_byte & COMP_MASK) != '0;
        enc        = (data_byte & ENC_MASK) != '0;

        // tag bytes left when the end-of-tag check runs
        unique case (ph_eff)
            PH_HDR:    chk_rem = rem_hdr;
            PH_EXTLEN: chk_rem = rem_ext;
            PH_FRHDR:  chk_rem = rem_after;
            default:   chk_rem = rem_eff;
        endcase
        chk_done = chk_rem <= PAD_BYTES;
    end

    // next state
    always_comb begin
        phase_next      = phase_reg;
        byte_index_next = byte_index_reg;
        ext_flag_next   = ext_flag_reg;
        rem_next        = rem_reg;
        id_next         = id_reg;
        len_next        = len_reg;
        body_next       = body_reg;
        kind_next       = kind_reg;
        pass_next       = pass_reg;
        if (in_fire) begin
            phase_next      = ph_eff;
            byte_index_next = idx_eff;
            ext_flag_next   = ext_eff;
            rem_next        = rem_eff;
            id_next         = id_eff;
            len_next        = len_eff;
            body_next       = body_eff;
            kind_next       = kind_eff;
            pass_next       = pass_eff;
            unique case (ph_eff)
                PH_HDR: begin
                    if (idx_eff == IDX_EXT_FLAG) begin
                        ext_flag_next = (data_byte & EXT_FLAG_MASK) != '0;
                    end
                    if (idx_eff >= IDX_SIZE_0) begin
                        rem_next = rem_hdr;
                    end
                    if (idx_eff >= IDX_HDR_LAST) begin
                        if (ext_eff) begin
                            phase_next      = PH_EXTLEN;
                            byte_index_next = '0;
                            len_next        = '0;
                        end else begin
                            phase_next = chk_done ? PH_IDLE : PH_FRHDR;
                        end
                    end else begin
                        byte_index_next = idx_eff + 4'd1;
                    end
                end
                PH_EXTLEN: begin
                    len_next = len_shift;
                    if (idx_eff >= IDX_EXT_LAST) begin
                        if (ext_short) begin
                            phase_next = PH_IDLE;
                        end else begin
                            rem_next = rem_ext;
                            if (ext_len > EXT_MIN_LEN) begin
                                phase_next = PH_EXTSKIP;
                                body_next  = ext_len - EXT_MIN_LEN;
                            end else begin
                                phase_next = chk_done ? PH_IDLE : PH_FRHDR;
                            end
                        end
                    end else begin
                        byte_index_next = idx_eff + 4'd1;
                    end
                end
                PH_EXTSKIP: begin
                    body_next = body_dec;
                    if (body_dec == '0) begin
                        phase_next = chk_done ? PH_IDLE : PH_FRHDR;
                    end
                end
                PH_FRHDR: begin
                    if (idx_eff < IDX_ID_END) begin
                        id_next = {id_eff[23:0], data_byte};
                    end else if (idx_eff < IDX_LEN_END) begin
                        len_next = len_shift;
                    end
                    if (idx_eff >= IDX_FRH_LAST) begin
                        kind_next = kind_new;
                        rem_next  = rem_less10;
                        if (frame_ovr) begin
                            phase_next = PH_IDLE;
                        end else begin
                            rem_next  = rem_after;
                            pass_next = (kind_new != KIND_OTHER) && !comp && !enc;
                            if (len_eff == '0) begin
                                phase_next = chk_done ? PH_IDLE : PH_FRHDR;
                            end else begin
                                phase_next = PH_BODY;
                                body_next  = len_eff;
                            end
                        end
                    end else begin
                        byte_index_next = idx_eff + 4'd1;
                    end
                end
                PH_BODY: begin
                    body_next = body_dec;
                    if (body_dec == '0) begin
                        phase_next = chk_done ? PH_IDLE : PH_FRHDR;
                    end
                end
                default: begin
                end
            endcase
            // entering a frame header clears its collectors
            if (phase_next == PH_FRHDR && ph_eff != PH_FRHDR) begin
                byte_index_next = '0;
                id_next         = '0;
                len_next        = '0;
            end
            if (ph_eff == PH_FRHDR && idx_eff >= IDX_FRH_LAST && phase_next == PH_FRHDR) begin
                byte_index_next = '0;
                id_next         = '0;
                len_next        = '0;
            end
        end
    end

    // results for this byte
    always_comb begin
        res_a = '0;
        res_d = '0;
        a_v   = 1'b0;
        d_v   = 1'b0;
        res_a.frame_kind = KIND_OTHER;
        res_d.event_res  = EV_DONE;
        res_d.frame_kind = KIND_OTHER;
        if (in_fire) begin
            unique case (ph_eff)
                PH_HDR: begin
                    d_v = (idx_eff >= IDX_HDR_LAST) && !ext_eff && chk_done;
                end
                PH_EXTLEN: begin
                    if (idx_eff >= IDX_EXT_LAST) begin
                        if (ext_short) begin
                            a_v             = 1'b1;
                            res_a.event_res = EV_ERROR;
                        end else begin
                            d_v = (ext_len <= EXT_MIN_LEN) && chk_done;
                        end
                    end
                end
                PH_EXTSKIP: begin
                    d_v = (body_dec == '0) && chk_done;
                end
                PH_FRHDR: begin
                    if (idx_eff >= IDX_FRH_LAST) begin
                        a_v = 1'b1;
                        if (frame_ovr) begin
                            res_a.event_res = EV_ERROR;
                        end else begin
                            res_a.event_res     = EV_FOUND;
                            res_a.frame_kind    = kind_new;
                            res_a.frame_length  = len_eff;
                            res_a.is_compressed = comp;
                            res_a.is_encrypted  = enc;
                            d_v = (len_eff == '0) && chk_done;
                        end
                    end
                end
                PH_BODY: begin
                    a_v                = pass_eff;
                    res_a.event_res    = EV_BYTE;
                    res_a.frame_kind   = kind_eff;
                    res_a.frame_length = len_eff;
                    res_a.payload      = data_byte;
                    res_a.frame_end    = body_dec == '0;
                    d_v = (body_dec == '0) && chk_done;
                end
                default: begin
                end
            endcase
        end
        res_d.last = 1'b1;
        res_a.last = !d_v;
        push.v0 = a_v || d_v;
        push.v1 = a_v && d_v;
        push.r0 = a_v ? res_a : res_d;
        push.r1 = res_d;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            byte_index_reg <= '0;
            ext_flag_reg   <= 1'b0;
            rem_reg        <= '0;
            id_reg         <= '0;
            len_reg        <= '0;
            body_reg       <= '0;
            kind_reg       <= KIND_OTHER;
            pass_reg       <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            byte_index_reg <= byte_index_next;
            ext_flag_reg   <= ext_flag_next;
            rem_reg        <= rem_next;
            id_reg         <= id_next;
            len_reg        <= len_next;
            body_reg       <= body_next;
            kind_reg       <= kind_next;
            pass_reg       <= pass_next;
        end
    end

    // a second result is always the tag done that follows a frame or byte
    a_second_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v1 |-> (push.v0 && push.r1.event_res == EV_DONE &&
                     push.r0.event_res != EV_ERROR))
        else $error("second result is not a done after found or byte");

    // an error ends the walk
    a_error_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.v0 && push.r0.event_res == EV_ERROR) |=> (phase_reg == PH_IDLE))
        else $error("walker did not go idle after an error");

    // bytes outside a tag without a start give nothing
    a_idle_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !start_req && phase_reg == PH_IDLE) |-> !push.v0)
        else $error("result produced while idle");

endmodule

[design/id3fw_res_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_res_fifo
// Result queue: takes one or two results a cycle, hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module id3fw_res_fifo #(
    parameter int DEPTH_LOG2 = id3fw_pkg::RES_FIFO_LOG2
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  id3fw_pkg::res_push_t  push,
    output logic                  room_two,
    output logic                  out_valid,
    input  logic                  out_ready,
    output id3fw_pkg::res_t       out_res
);
    import id3fw_pkg::*;

    localparam int DEPTH = 1 << DEPTH_LOG2;

    res_t                  mem [DEPTH];
    logic [DEPTH_LOG2-1:0] wr_ptr_reg, wr_ptr_next;
    logic [DEPTH_LOG2-1:0] rd_ptr_reg, rd_ptr_next;
    logic [DEPTH_LOG2:0]   count_reg, count_next;
    logic                  pop;

    // pointer and occupancy update
    always_comb begin
        pop         = out_valid && out_ready;
        wr_ptr_next = wr_ptr_reg + DEPTH_LOG2'(push.v0) + DEPTH_LOG2'(push.v1);
        rd_ptr_next = rd_ptr_reg + DEPTH_LOG2'(pop);
        count_next  = count_reg + (DEPTH_LOG2 + 1)'(push.v0) + (DEPTH_LOG2 + 1)'(push.v1)
                      - (DEPTH_LOG2 + 1)'(pop);
    end

    assign room_two  = count_reg <= (DEPTH_LOG2 + 1)'(DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_res   = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push.v0) begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1) begin
            mem[wr_ptr_reg + DEPTH_LOG2'(1)] <= push.r1;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (DEPTH_LOG2 + 1)'(DEPTH))
        else $error("result queue overflow");

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.v0 |-> room_two)
        else $error("results written without room for two");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push.v0) |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("occupancy wrong after a lone read");

endmodule

[design/id3v2_frame_walker_unit.sv]
`timescale 1ns / 1ps
// Results of an accepted byte are stored in the result queue and offered from there.
// Throughput: one byte per cycle while the queue has room for two; a byte that gives
// two results (frame plus tag done) leaves through the single read port of the
// result queue one result at a time; the queue holds four results.
// Reset: aresetn synchronous, active low; walker idle, queue empty.
// ----------------------------------------------------------------------------
// id3v2_frame_walker_unit
// ID3v2 tag walker with stream ports: reports frames, passes wanted payload.
// ----------------------------------------------------------------------------
module id3v2_frame_walker_unit #(
    parameter int RES_FIFO_LOG2 = id3fw_pkg::RES_FIFO_LOG2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_req
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [31:0] frame_length, [32] is_compressed,
                                        // [33] is_encrypted, [41:34] payload,
                                        // [42] frame_end, [47:43] zero
    output logic [4:0]  m_axis_tuser,   // [1:0] event_res, [4:2] frame_kind
    output logic        m_axis_tlast    // last
);
    import id3fw_pkg::*;

    res_push_t push;
    res_t      out_res;
    logic      room_two;
    logic      in_fire;

    // input transaction
    assign s_axis_tready = room_two;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    id3fw_walk u_walk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .start_req (s_axis_tuser),
        .data_byte (s_axis_tdata),
        .push      (push)
    );

    id3fw_res_fifo #(
        .DEPTH_LOG2 (RES_FIFO_LOG2)
    ) u_res_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room_two  (room_two),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    // result packing
    assign m_axis_tdata = {5'd0, out_res.frame_end, out_res.payload, out_res.is_encrypted,
                           out_res.is_compressed, out_res.frame_length};
    assign m_axis_tuser = {out_res.frame_kind, out_res.event_res};
    assign m_axis_tlast = out_res.last;

endmodule

[test/id3fw_result_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3fw_result_checker
// Watches both stream channels of the ID3v2 frame walker. It runs its own
// walk of the tag for every accepted input byte, queues the results that the
// byte should give and compares every result transaction with the oldest one,
// field by field. Mismatch count and queue depth go back to the testbench.
// ----------------------------------------------------------------------------
module id3fw_result_checker
    import id3fw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] start_req
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,   // [31:0] frame_length, [32] is_compressed,
                                        // [33] is_encrypted, [41:34] payload,
                                        // [42] frame_end, [47:43] zero
    input  logic [4:0]  m_axis_tuser,   // [1:0] event_res, [4:2] frame_kind
    input  logic        m_axis_tlast,
    output int          mismatch_count,
    output int          events_pending
);

    // walker state as tracked by the checker
    phase_t      walk_phase;
    logic [3:0]  hdr_pos;
    logic        ext_present;
    logic [27:0] tag_left;
    logic [31:0] id_shift;
    logic [31:0] len_shift;
    logic [31:0] bytes_left;
    logic [2:0]  kind_now;
    logic        forward_payload;

    // results of the byte being walked, then the store of expected results
    res_t step_out [2];
    int   step_n;
    res_t expected_events [$];
    res_t want;

    task automatic clear_walk();
        walk_phase      = PH_IDLE;
        hdr_pos         = '0;
        ext_present     = 1'b0;
        tag_left        = '0;
        id_shift        = '0;
        len_shift       = '0;
        bytes_left      = '0;
        kind_now        = KIND_OTHER;
        forward_payload = 1'b0;
    endtask

    task automatic add_event(input event_t ev, input logic [2:0] kind,
                             input logic [31:0] len, input logic comp, input logic enc,
                             input logic [7:0] pay, input logic fend);
        res_t r;
        r.event_res     = ev;
        r.frame_kind    = kind;
        r.frame_length  = len;
        r.is_compressed = comp;
        r.is_encrypted  = enc;
        r.payload       = pay;
        r.frame_end     = fend;
        r.last          = 1'b0;
        step_out[step_n] = r;
        step_n++;
    endtask

    // at a frame boundary: another frame header, or the tag is finished
    task automatic next_frame_or_done();
        if (tag_left > PAD_BYTES) begin
            walk_phase = PH_FRHDR;
            hdr_pos    = '0;
            id_shift   = '0;
            len_shift  = '0;
        end else begin
            add_event(EV_DONE, KIND_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
            walk_phase = PH_IDLE;
        end
    endtask

    task automatic abort_tag();
        add_event(EV_ERROR, KIND_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
        walk_phase = PH_IDLE;
    endtask

    // walk one accepted byte and queue the results it gives
    task automatic walk_byte(input logic start, input logic [7:0] b);
        logic [31:0] ext_len;
        logic        comp;
        logic        enc;
        step_n = 0;
        if (start) begin
            clear_walk();
            walk_phase = PH_HDR;
        end
        case (walk_phase)
            PH_HDR: begin
                if (hdr_pos == IDX_EXT_FLAG) ext_present = (b & EXT_FLAG_MASK) != 0;
                // syncsafe size, top bit of each byte dropped
                if (hdr_pos >= IDX_SIZE_0) tag_left = {tag_left[20:0], b[6:0]};
                if (hdr_pos >= IDX_HDR_LAST) begin
                    if (ext_present) begin
                        walk_phase = PH_EXTLEN;
                        hdr_pos    = '0;
                        len_shift  = '0;
                    end else begin
                        next_frame_or_done();
                    end
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_EXTLEN: begin
                len_shift = {len_shift[23:0], b};
                if (hdr_pos >= IDX_EXT_LAST) begin
                    ext_len = (len_shift < EXT_MIN_LEN) ? EXT_MIN_LEN : len_shift;
                    if ({4'd0, tag_left} < ext_len) begin
                        abort_tag();
                    end else begin
                        tag_left = tag_left - ext_len[27:0];
                        if (ext_len > EXT_MIN_LEN) begin
                            walk_phase = PH_EXTSKIP;
                            bytes_left = ext_len - EXT_MIN_LEN;
                        end else begin
                            next_frame_or_done();
                        end
                    end
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_EXTSKIP: begin
                if (bytes_left != 0) bytes_left = bytes_left - 32'd1;
                if (bytes_left == 0) next_frame_or_done();
            end
            PH_FRHDR: begin
                if (hdr_pos < IDX_ID_END) id_shift = {id_shift[23:0], b};
                else if (hdr_pos < IDX_LEN_END) len_shift = {len_shift[23:0], b};
                if (hdr_pos >= IDX_FRH_LAST) begin
                    comp     = (b & COMP_MASK) != 0;
                    enc      = (b & ENC_MASK) != 0;
                    kind_now = KIND_OTHER;
                    for (int k = 0; k < NUM_WANTED; k++) begin
                        if (id_shift == WANTED_IDS[k]) kind_now = 3'(k);
                    end
                    tag_left = tag_left - FRAME_HDR_LEN;
                    if ({4'd0, tag_left} < len_shift) begin
                        abort_tag();
                    end else begin
                        add_event(EV_FOUND, kind_now, len_shift, comp, enc, '0, 1'b0);
                        tag_left        = tag_left - len_shift[27:0];
                        forward_payload = (kind_now != KIND_OTHER) && !comp && !enc;
                        if (len_shift == 0) begin
                            next_frame_or_done();
                        end else begin
                            walk_phase = PH_BODY;
                            bytes_left = len_shift;
                        end
                    end
                end else begin
                    hdr_pos = hdr_pos + 4'd1;
                end
            end
            PH_BODY: begin
                if (bytes_left != 0) bytes_left = bytes_left - 32'd1;
                if (forward_payload)
                    add_event(EV_BYTE, kind_now, len_shift, 1'b0, 1'b0, b, bytes_left == 0);
                if (bytes_left == 0) next_frame_or_done();
            end
            default: begin
            end
        endcase
        if (step_n > 0) step_out[step_n - 1].last = 1'b1;
        for (int i = 0; i < step_n; i++) expected_events.push_back(step_out[i]);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            $display("%0t: mismatch in %s, expected %0h, actual %0h",
                     $time, name, want_v, got_v);
        end
    endtask

    // follow both channels at every clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_walk();
            expected_events.delete();
            mismatch_count = 0;
        end else begin
            // input transaction
            if (s_axis_tvalid && s_axis_tready) walk_byte(s_axis_tuser, s_axis_tdata);
            // result transaction
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result, expected none, %s %0h tdata %0h",
                             $time, "actual tuser", m_axis_tuser, m_axis_tdata);
                end else begin
                    want = expected_events.pop_front();
                    compare_field("event_res", want.event_res, m_axis_tuser[1:0]);
                    compare_field("frame_kind", want.frame_kind, m_axis_tuser[4:2]);
                    compare_field("frame_length", want.frame_length, m_axis_tdata[31:0]);
                    compare_field("is_compressed", want.is_compressed, m_axis_tdata[32]);
                    compare_field("is_encrypted", want.is_encrypted, m_axis_tdata[33]);
                    compare_field("payload", want.payload, m_axis_tdata[41:34]);
                    compare_field("frame_end", want.frame_end, m_axis_tdata[42]);
                    compare_field("last", want.last, m_axis_tlast);
                    compare_field("tdata fill", '0, m_axis_tdata[47:43]);
                end
            end
        end
        events_pending = expected_events.size();
    end

endmodule

[test/id3v2_frame_walker_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// id3v2_frame_walker_unit_tb
// Feeds the frame walker with ID3v2 tags: a short directed tag first, then
// random tags, mostly well formed with random content, some broken on
// purpose (overrunning frames, oversized extended headers, cut-off tags,
// wrong sizes) and some stray bytes. Both sides idle at random; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module id3v2_frame_walker_unit_tb;
    import id3fw_pkg::*;

    localparam int RANDOM_ITEMS  = 1850;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int BUDGET_NONE   = 1 << 30;

    // one byte of the input stream with its start marker
    typedef struct packed {
        logic       start;
        logic [7:0] value;
    } stream_byte_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [4:0]  m_axis_tuser;
    logic        m_axis_tlast;

    int           mismatch_count;
    int           events_pending;
    int           cycle_count = 0;
    int           tag_budget = BUDGET_NONE;
    int           directed_len;
    int           mid_drain = -1;
    int           hold_idx;
    bit           hold_req = 1'b0;
    bit           hold_done = 1'b0;
    stream_byte_t tag_stream [$];
    logic [7:0]   frame_area [$];

    id3v2_frame_walker_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    id3fw_result_checker result_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .m_axis_tuser   (m_axis_tuser),
        .m_axis_tlast   (m_axis_tlast),
        .mismatch_count (mismatch_count),
        .events_pending (events_pending)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long, with quiet stretches
    function automatic int pick_gap();
        int r;
        if ((cycle_count % 1500) < 300) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // append a byte unless the current tag has been cut off
    task automatic put(input logic start, input logic [7:0] v);
        if (tag_budget > 0) begin
            tag_stream.push_back({start, v});
            tag_budget--;
        end
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) put(1'b0, w[8*i +: 8]);
    endtask

    task automatic area_word(input logic [31:0] w);
        for (int i = 3; i >= 0; i--) frame_area.push_back(w[8*i +: 8]);
    endtask

    // one random tag, sometimes broken on purpose
    task automatic build_tag();
        int          fault;
        int          n_frames;
        int          pad_len;
        int          ext_len;
        int          ext_total;
        int          flen;
        int          r;
        logic        use_ext;
        logic [31:0] fid;
        logic [31:0] len_field;
        logic [31:0] ext_field;
        logic [27:0] size_val;
        logic [7:0]  fmt;

        // fault: 0 last frame overruns, 1 extended header too long,
        // 2 tag cut off by the next start, 3 wrong tag size
        fault     = $urandom_range(0, 9);
        n_frames  = $urandom_range(0, 4);
        pad_len   = $urandom_range(0, 14);
        use_ext   = (fault == 1) || ($urandom_range(0, 3) == 0);
        ext_len   = $urandom_range(0, 12);
        ext_total = use_ext ? ((ext_len < 4) ? 4 : ext_len) : 0;
        frame_area.delete();

        // frames: mostly wanted ids, some random ids and near misses
        for (int k = 0; k < n_frames; k++) begin
            r = $urandom_range(0, 9);
            if (r < NUM_WANTED) fid = WANTED_IDS[r];
            else if (r < 8) fid = $urandom();
            else fid = WANTED_IDS[$urandom_range(0, NUM_WANTED - 1)]
                       ^ (32'd1 << $urandom_range(0, 31));
            r = $urandom_range(0, 19);
            if (r < 3) flen = 0;
            else if (r < 17) flen = $urandom_range(1, 8);
            else if (r < 19) flen = $urandom_range(9, 40);
            else flen = $urandom_range(41, 120);
            len_field = flen;
            if (fault == 0 && k == n_frames - 1) begin
                r = $urandom_range(0, 2);
                if (r == 0) len_field = 32'hFFFF_FFFF;
                else if (r == 1) len_field = flen + pad_len + 1;
                else len_field = flen + $urandom_range(pad_len + 1, 3000);
            end
            fmt = ($urandom_range(0, 9) < 7) ? (8'($urandom()) & ~(COMP_MASK | ENC_MASK))
                                             : 8'($urandom());
            area_word(fid);
            area_word(len_field);
            frame_area.push_back(8'($urandom()));
            frame_area.push_back(fmt);
            repeat (flen) frame_area.push_back(8'($urandom()));
        end
        // padding, mostly zero
        repeat (pad_len)
            frame_area.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom()) : 8'h00);

        size_val = 28'(ext_total + frame_area.size());
        if (fault == 3) size_val = 28'($urandom_range(0, size_val));
        ext_field = ext_len;
        if (fault == 1)
            ext_field = ($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF
                                                   : size_val + $urandom_range(1, 3);
        tag_budget = (fault == 2) ? $urandom_range(1, 9 + ext_total + frame_area.size())
                                  : BUDGET_NONE;

        // tag header
        put(1'b1, ($urandom_range(0, 3) == 0) ? 8'($urandom()) : 8'h49);
        put(1'b0, 8'h44);
        put(1'b0, 8'h33);
        put(1'b0, 8'($urandom_range(2, 4)));
        put(1'b0, 8'h00);
        put(1'b0, (8'($urandom()) & ~EXT_FLAG_MASK) | (use_ext ? EXT_FLAG_MASK : 8'h00));
        for (int k = 3; k >= 0; k--)
            put(1'b0, {1'($urandom_range(0, 3) == 0), 7'(size_val >> (7 * k))});
        // extended header and its body
        if (use_ext) begin
            put_word(ext_field);
            repeat (ext_total - 4) put(1'b0, 8'($urandom()));
        end
        foreach (frame_area[k]) put(1'b0, frame_area[k]);
        tag_budget = BUDGET_NONE;

        // stray bytes between tags
        if ($urandom_range(0, 6) == 0)
            repeat ($urandom_range(1, 3)) put(1'b0, 8'($urandom()));
    endtask

    // result side: random stalls, one long hold-off
    initial begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (hold_req && !hold_done) begin
                // long hold-off so the result queue fills and the input backs up
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            stall = pick_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
    end

    // input side: stimulus and verdict
    initial begin : byte_source
        int gap;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tuser  = 1'b0;

        // stray byte while idle, then a tag with an extended header length
        // below the minimum and a single empty TLEN frame that ends the tag,
        // so the frame and the tag end come from the same byte
        put(1'b0, 8'h00);
        put(1'b1, 8'h49);
        put(1'b0, 8'h44);
        put(1'b0, 8'h33);
        put(1'b0, 8'h04);
        put(1'b0, 8'h00);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h80);
        put(1'b0, 8'h80);
        put(1'b0, 8'h80);
        put(1'b0, 8'h8F);
        put_word(32'h0000_0000);
        put_word(WANTED_IDS[0]);
        put_word(32'h0000_0000);
        put(1'b0, 8'hFF);
        put(1'b0, 8'h00);
        directed_len = tag_stream.size();

        // random tags
        while (tag_stream.size() < directed_len + RANDOM_ITEMS) begin
            if (mid_drain < 0 && tag_stream.size() >= directed_len + RANDOM_ITEMS / 2)
                mid_drain = tag_stream.size();
            build_tag();
        end
        hold_idx = directed_len + (tag_stream.size() - directed_len) * 3 / 4;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (tag_stream[idx]) begin
            // sender pause until every outstanding result has arrived
            if (idx == directed_len || idx == mid_drain) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (events_pending != 0) @(posedge aclk);
            end
            if (idx == hold_idx) hold_req = 1'b1;
            gap = (hold_req && !hold_done) ? 0 : pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tuser  <= tag_stream[idx].start;
            s_axis_tdata  <= tag_stream[idx].value;
            @(posedge aclk);
            while (!s_axis_tready) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b0;

        // let the last results drain
        @(posedge aclk);
        while (events_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
